// File: sv/cartesian_pid_jacobian_torque_unit_defines.svh
`ifndef CARTESIAN_PID_JACOBIAN_TORQUE_UNIT_DEFINES_SVH
`define CARTESIAN_PID_JACOBIAN_TORQUE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define CPJT_CHECK_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define CPJT_CHECK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/cpjt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cpjt_pkg;

   typedef enum logic [1:0] {
      OP_EVAL  = 2'd0,
      OP_JOINT = 2'd1,
      OP_HOLD  = 2'd2,
      OP_IDLE  = 2'd3
   } op_type;

   localparam logic [1:0] CSR_KP = 2'd0;
   localparam logic [1:0] CSR_KI = 2'd1;
   localparam logic [1:0] CSR_KD = 2'd2;

   localparam int MUL_A_W = 17;
   localparam int MUL_B_W = 49;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int SUM_W   = PROD_W - 6;

   typedef enum logic [14:0] {
      S_IDLE = 15'h0001,
      S_ERR  = 15'h0002,
      S_DTL  = 15'h0004,
      S_DTH  = 15'h0008,
      S_DTS  = 15'h0010,
      S_INT  = 15'h0020,
      S_KP   = 15'h0040,
      S_KI   = 15'h0080,
      S_KD   = 15'h0100,
      S_KDS  = 15'h0200,
      S_FRC  = 15'h0400,
      S_JMUL = 15'h0800,
      S_JACC = 15'h1000,
      S_JOUT = 15'h2000,
      S_PUB  = 15'h4000
   } state_type;

   typedef struct packed {
      state_type  state;
      logic [1:0] axis;
   } ctl_type;

   localparam logic signed [63:0] I32_MAX = 64'sd2147483647;
   localparam logic signed [63:0] I32_MIN = -64'sd2147483648;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > I32_MAX) begin
         r = 32'sh7FFFFFFF;
      end else if (x < I32_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   function automatic logic [15:0] gain_sel(input logic [47:0] g, input logic [1:0] ax);
      logic [15:0] r;
      case (ax)
         2'd0:    r = g[15:0];
         2'd1:    r = g[31:16];
         default: r = g[47:32];
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// File: sv/cartesian_pid_jacobian_torque_unit.sv
`timescale 1ns / 1ps
`default_nettype none
`include "cartesian_pid_jacobian_torque_unit_defines.svh"

// Three-axis Cartesian PID hold controller with Jacobian-transpose torque.
// req_tuser carries the op (eval, joint, hold, idle); every accepted beat
// yields one rsp beat with the stored force, the joint torque and the hold
// flag. Gains are to be written on the csr channel only while the block is
// idle; the block itself does not enforce this. All arithmetic runs through
// one registered 17x49 signed multiplier stepped by a small sequencer, one
// item at a time: hold, idle, and an eval or joint op while not holding go
// straight to publish; a joint op while holding runs three multiplies for
// the dot product plus shift, add and saturate; an eval while holding runs,
// per axis, two multiplies for error*dt, integrator update, three gain
// multiplies and force saturate. req_tready is low while an item is worked
// on and while a finished result waits for a free rsp register.

module cartesian_pid_jacobian_torque_unit
   import cpjt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,

   input  wire logic         req_tvalid,
   output logic              req_tready,
   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, tick_time, jac_x, jac_y, jac_z,
   // torque_in
   input  wire logic [303:0] req_tdata,
   // op
   input  wire logic [1:0]   req_tuser,

   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // force_x, force_y, force_z, torque_out
   output logic [127:0]      rsp_tdata,
   // holding
   output logic [0:0]        rsp_tuser,

   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [47:0]  csr_data
);

   localparam logic signed [PROD_W-1:0] INC_HI = 66'sd140737488355328;
   localparam logic signed [PROD_W-1:0] INC_LO = -66'sd140737488355328;
   localparam logic signed [49:0] INT_HI = 50'sd140737488355327;
   localparam logic signed [49:0] INT_LO = -50'sd140737488355328;

   ctl_type ctl;
   logic    accept;
   logic    pub_ok;
   op_type  op;

   logic [47:0] kp_ff, ki_ff, kd_ff;

   logic signed [31:0] pos_ff [3];
   logic signed [31:0] vel_ff [3];
   logic signed [15:0] jac_ff [3];
   logic signed [31:0] tin_ff;

   logic signed [31:0] ref_ff [3];
   logic signed [47:0] integ_ff [3];
   logic signed [31:0] force_ff [3];
   logic               hold_ff;
   logic               time_valid_ff;
   logic [31:0]        prev_ff;
   logic [31:0]        dt_ff;

   logic signed [32:0]       err_ff;
   logic signed [PROD_W-1:0] acc_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [31:0]       torque_ff;

   logic signed [31:0] rsp_force_ff [3];
   logic signed [31:0] rsp_torque_ff;
   logic               rsp_hold_ff;
   logic               rsp_valid_ff;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod;
   logic signed [SUM_W-1:0]   prod_sh;

   logic signed [48:0] inc;
   logic signed [49:0] int_sum;
   logic signed [47:0] int_new;
   logic signed [SUM_W:0] neg_sum;
   logic signed [46:0] tq_sum;

   assign op         = op_type'(req_tuser);
   assign req_tready = (ctl.state == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign pub_ok     = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   cpjt_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .op      (op),
      .holding (hold_ff),
      .pub_ok  (pub_ok),
      .ctl     (ctl)
   );

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (ctl.state)
         S_DTL: begin
            mul_a = {1'b0, dt_ff[15:0]};
            mul_b = {{16{err_ff[32]}}, err_ff};
         end
         S_DTH: begin
            mul_a = {1'b0, dt_ff[31:16]};
            mul_b = {{16{err_ff[32]}}, err_ff};
         end
         S_KP: begin
            mul_a = {1'b0, gain_sel(kp_ff, ctl.axis)};
            mul_b = {{16{err_ff[32]}}, err_ff};
         end
         S_KI: begin
            mul_a = {1'b0, gain_sel(ki_ff, ctl.axis)};
            mul_b = {integ_ff[ctl.axis][47], integ_ff[ctl.axis]};
         end
         S_KD: begin
            mul_a = {1'b0, gain_sel(kd_ff, ctl.axis)};
            mul_b = {{17{vel_ff[ctl.axis][31]}}, vel_ff[ctl.axis]};
         end
         S_JMUL: begin
            mul_a = {jac_ff[ctl.axis][15], jac_ff[ctl.axis]};
            mul_b = {{17{force_ff[ctl.axis][31]}}, force_ff[ctl.axis]};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   cpjt_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod)
   );

   assign prod_sh = prod[PROD_W-1:6];

   always_comb begin
      if (acc_ff > INC_HI) begin
         inc = INC_HI[48:0];
      end else if (acc_ff < INC_LO) begin
         inc = INC_LO[48:0];
      end else begin
         inc = acc_ff[48:0];
      end
      int_sum = {{2{integ_ff[ctl.axis][47]}}, integ_ff[ctl.axis]} + {inc[48], inc};
      if (int_sum > INT_HI) begin
         int_new = INT_HI[47:0];
      end else if (int_sum < INT_LO) begin
         int_new = INT_LO[47:0];
      end else begin
         int_new = int_sum[47:0];
      end
   end

   assign neg_sum = -{sum_ff[SUM_W-1], sum_ff};
   assign tq_sum  = {sum_ff[SUM_W-1], sum_ff[SUM_W-1:14]}
                  + {{15{tin_ff[31]}}, tin_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff <= '0;
         ki_ff <= '0;
         kd_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_KP:  kp_ff <= csr_data;
            CSR_KI:  ki_ff <= csr_data;
            CSR_KD:  kd_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= req_tdata[32*i +: 32];
            vel_ff[i] <= req_tdata[96 + 32*i +: 32];
            jac_ff[i] <= req_tdata[224 + 16*i +: 16];
         end
         tin_ff <= req_tdata[303:272];
      end
      case (ctl.state)
         S_ERR: err_ff <= {pos_ff[ctl.axis][31], pos_ff[ctl.axis]}
                        - {ref_ff[ctl.axis][31], ref_ff[ctl.axis]};
         S_DTH: acc_ff <= prod;
         S_DTS: acc_ff <= acc_ff + {prod[PROD_W-17:0], 16'b0};
         S_KI:  sum_ff <= prod_sh;
         S_KD:  sum_ff <= sum_ff + prod_sh;
         S_KDS: sum_ff <= sum_ff + prod_sh;
         S_JMUL: begin
            if (ctl.axis == 2'd0) begin
               sum_ff <= '0;
            end else begin
               sum_ff <= sum_ff + prod[SUM_W-1:0];
            end
         end
         S_JACC: sum_ff <= sum_ff + prod[SUM_W-1:0];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            ref_ff[i]   <= '0;
            integ_ff[i] <= '0;
            force_ff[i] <= '0;
         end
         hold_ff       <= 1'b0;
         time_valid_ff <= 1'b0;
         prev_ff       <= '0;
         dt_ff         <= '0;
         torque_ff     <= '0;
      end else begin
         if (accept) begin
            torque_ff <= (op == OP_JOINT && !hold_ff) ? req_tdata[303:272] : '0;
            case (op)
               OP_HOLD: begin
                  for (int i = 0; i < 3; i++) begin
                     ref_ff[i]   <= req_tdata[32*i +: 32];
                     integ_ff[i] <= '0;
                  end
                  time_valid_ff <= 1'b0;
                  hold_ff       <= 1'b1;
               end
               OP_IDLE: hold_ff <= 1'b0;
               OP_EVAL: begin
                  if (hold_ff) begin
                     dt_ff         <= time_valid_ff ? (req_tdata[223:192] - prev_ff) : '0;
                     prev_ff       <= req_tdata[223:192];
                     time_valid_ff <= 1'b1;
                  end
               end
               default: ;
            endcase
         end
         case (ctl.state)
            S_INT:  integ_ff[ctl.axis] <= int_new;
            S_FRC:  force_ff[ctl.axis] <= sat32({{(63 - SUM_W){neg_sum[SUM_W]}}, neg_sum});
            S_JOUT: torque_ff <= sat32({{17{tq_sum[46]}}, tq_sum});
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.state == S_PUB && pub_ok) begin
         for (int i = 0; i < 3; i++) begin
            rsp_force_ff[i] <= force_ff[i];
         end
         rsp_torque_ff <= torque_ff;
         rsp_hold_ff   <= hold_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.state == S_PUB && pub_ok) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_torque_ff, rsp_force_ff[2], rsp_force_ff[1], rsp_force_ff[0]};
   assign rsp_tuser  = rsp_hold_ff;

   `CPJT_CHECK_IMPL(a_busy_needs_hold, (ctl.state != S_IDLE) && (ctl.state != S_PUB), hold_ff, "sequence running while not holding")
   `CPJT_CHECK_IMPL(a_axis_range, ctl.state != S_IDLE, ctl.axis != 2'd3, "axis counter out of range")
   `CPJT_CHECK_NEXT(a_hold_arms, accept && (op == OP_HOLD), hold_ff && !time_valid_ff, "hold did not arm")
   `CPJT_CHECK_NEXT(a_pub_loads, (ctl.state == S_PUB) && pub_ok, rsp_tvalid && (ctl.state == S_IDLE), "result beat not loaded")

endmodule

`default_nettype wire

// File: sv/cpjt_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module cpjt_mul
   import cpjt_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic signed [MUL_A_W-1:0] mul_a,
   input  wire logic signed [MUL_B_W-1:0] mul_b,
   output logic signed [PROD_W-1:0]       prod_ff
);

   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = {{MUL_B_W{mul_a[MUL_A_W-1]}}, mul_a}
                  * {{MUL_A_W{mul_b[MUL_B_W-1]}}, mul_b};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

// File: sv/cpjt_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module cpjt_seq
   import cpjt_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   start,
   input  wire op_type op,
   input  wire logic   holding,
   input  wire logic   pub_ok,
   output ctl_type     ctl
);

   state_type  state_ff, state_in;
   logic [1:0] axis_ff, axis_in;

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      case (state_ff)
         S_IDLE: begin
            axis_in = 2'd0;
            if (start) begin
               case (op)
                  OP_EVAL:  state_in = holding ? S_ERR : S_PUB;
                  OP_JOINT: state_in = holding ? S_JMUL : S_PUB;
                  default:  state_in = S_PUB;
               endcase
            end
         end
         S_ERR: state_in = S_DTL;
         S_DTL: state_in = S_DTH;
         S_DTH: state_in = S_DTS;
         S_DTS: state_in = S_INT;
         S_INT: state_in = S_KP;
         S_KP:  state_in = S_KI;
         S_KI:  state_in = S_KD;
         S_KD:  state_in = S_KDS;
         S_KDS: state_in = S_FRC;
         S_FRC: begin
            if (axis_ff == 2'd2) begin
               state_in = S_PUB;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = S_ERR;
            end
         end
         S_JMUL: begin
            if (axis_ff == 2'd2) begin
               state_in = S_JACC;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         S_JACC: state_in = S_JOUT;
         S_JOUT: state_in = S_PUB;
         S_PUB: begin
            if (pub_ok) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         axis_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
   end

   assign ctl.state = state_ff;
   assign ctl.axis  = axis_ff;

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import cpjt_pkg::*;

   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S32_MIN = -64'sd2147483648;
   localparam longint LIM47 = 64'sd140737488355328;
   localparam logic [63:0] LIM47_U = 64'h0000_8000_0000_0000;
   localparam logic [31:0] W_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] W_MIN = 32'h8000_0000;
   localparam logic [47:0] G_ONES = 48'hFFFF_FFFF_FFFF;

   class hold_ctrl_predictor;
      longint ref_pos[3];
      longint integ[3];
      longint frc[3];
      bit holding;
      logic [31:0] prev_tick;
      bit tick_ok;
      logic [47:0] gains[3];
      logic [159:0] force_torque_q[$];
      string field_name[5] = '{"force_x", "force_y", "force_z", "torque_out", "holding"};
      int mismatches;
      int checked;
      int seen_op[4];

      function new();
         for (int i = 0; i < 3; i++) begin
            ref_pos[i] = 0;
            integ[i] = 0;
            frc[i] = 0;
            gains[i] = '0;
         end
         holding = 0;
         prev_tick = '0;
         tick_ok = 0;
         mismatches = 0;
         checked = 0;
         for (int i = 0; i < 4; i++) seen_op[i] = 0;
      endfunction

      function longint s32(logic [31:0] x);
         logic signed [31:0] t;
         t = x;
         return t;
      endfunction

      function longint s16(logic [15:0] x);
         logic signed [15:0] t;
         t = x;
         return t;
      endfunction

      function logic [31:0] clip32(longint x);
         if (x > S32_MAX) return W_MAX;
         if (x < S32_MIN) return W_MIN;
         return x[31:0];
      endfunction

      function longint gain_of(int k, int axis);
         longint g;
         g = gains[k][16*axis +: 16];
         return g;
      endfunction

      function void set_gain(logic [1:0] idx, logic [47:0] value);
         case (idx)
            CSR_KP:  gains[0] = value;
            CSR_KI:  gains[1] = value;
            CSR_KD:  gains[2] = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return force_torque_q.size();
      endfunction

      function void accept_cmd(op_type op, logic [303:0] d);
         longint pos[3], vel[3];
         longint err, inc, acc, sum, dot, tin;
         logic [31:0] now, trq;
         logic [63:0] dt, mag, prod;
         trq = '0;
         seen_op[op]++;
         for (int i = 0; i < 3; i++) begin
            pos[i] = s32(d[32*i +: 32]);
            vel[i] = s32(d[96 + 32*i +: 32]);
         end
         case (op)
            OP_HOLD: begin
               for (int i = 0; i < 3; i++) begin
                  ref_pos[i] = pos[i];
                  integ[i] = 0;
               end
               tick_ok = 0;
               holding = 1;
            end
            OP_IDLE: holding = 0;
            OP_EVAL: begin
               if (holding) begin
                  now = d[223:192];
                  if (!tick_ok) begin
                     prev_tick = now;
                     tick_ok = 1;
                  end
                  dt = {32'd0, now - prev_tick};
                  prev_tick = now;
                  for (int i = 0; i < 3; i++) begin
                     err = pos[i] - ref_pos[i];
                     mag = (err < 0) ? -err : err;
                     prod = mag * dt;
                     if (prod > LIM47_U) prod = LIM47_U;
                     inc = (err < 0) ? -longint'(prod) : longint'(prod);
                     acc = integ[i] + inc;
                     if (acc > LIM47 - 1) acc = LIM47 - 1;
                     if (acc < -LIM47) acc = -LIM47;
                     integ[i] = acc;
                     sum = ((gain_of(0, i) * err) >>> 6)
                         + ((gain_of(1, i) * acc) >>> 6)
                         + ((gain_of(2, i) * vel[i]) >>> 6);
                     frc[i] = s32(clip32(-sum));
                  end
               end
            end
            default: begin
               tin = s32(d[303:272]);
               if (holding) begin
                  dot = 0;
                  for (int i = 0; i < 3; i++) dot += s16(d[224 + 16*i +: 16]) * frc[i];
                  trq = clip32(tin + (dot >>> 14));
               end else begin
                  trq = d[303:272];
               end
            end
         endcase
         force_torque_q.push_back({31'd0, holding, trq,
                                   frc[2][31:0], frc[1][31:0], frc[0][31:0]});
      endfunction

      function void flag(string what, logic [31:0] want, logic [31:0] got);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch at rsp beat %0d, %s: expected %h, got %h",
                     checked, what, want, got);
      endfunction

      function void match_result(logic [127:0] d, logic h);
         logic [159:0] want, got;
         got = {31'd0, h, d};
         if (force_torque_q.size() == 0) begin
            flag("beat with nothing pending", '0, d[31:0]);
         end else begin
            want = force_torque_q.pop_front();
            for (int i = 0; i < 5; i++)
               if (want[32*i +: 32] !== got[32*i +: 32])
                  flag(field_name[i], want[32*i +: 32], got[32*i +: 32]);
         end
         checked++;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic [303:0] req_tdata = '0;
   logic [1:0] req_tuser = OP_IDLE;
   logic rsp_tready = 1'b0;
   logic csr_valid = 1'b0;
   logic [1:0] csr_index = CSR_KP;
   logic [47:0] csr_data = '0;
   logic req_tready, rsp_tvalid, csr_ready;
   logic [127:0] rsp_tdata;
   logic [0:0] rsp_tuser;

   int send_pct = 0;
   int stall_pct = 0;
   logic [31:0] tick_now = '0;
   logic [95:0] hold_pos = '0;

   hold_ctrl_predictor sb = new();

   cartesian_pid_jacobian_torque_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.accept_cmd(op_type'(req_tuser), req_tdata);
         if (rsp_tvalid && rsp_tready) sb.match_result(rsp_tdata, rsp_tuser[0]);
         if (csr_valid && csr_ready) sb.set_gain(csr_index, csr_data);
      end
   end

   function automatic logic [303:0] pack_req(logic [95:0] pos, logic [95:0] vel,
                                             logic [31:0] tick, logic [47:0] jac,
                                             logic [31:0] tin);
      return {tin, jac, tick, vel, pos};
   endfunction

   function automatic logic [31:0] rnd_word(int full_pct, int span);
      if ($urandom_range(99) < full_pct) return $urandom();
      return $urandom_range(2 * span) - span;
   endfunction

   task automatic send_req(op_type op, logic [303:0] data);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < send_pct) gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= data;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [47:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_gains(logic [47:0] kp, logic [47:0] ki, logic [47:0] kd);
      write_csr(CSR_KP, kp);
      write_csr(CSR_KI, ki);
      write_csr(CSR_KD, kd);
   endtask

   task automatic wait_all_done();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic run_random(int n);
      int r;
      op_type op;
      logic [95:0] p, v;
      logic [47:0] j;
      logic [31:0] tk, tin;
      for (int k = 0; k < n; k++) begin
         r = (k == 0) ? 10 : $urandom_range(99);
         if (r < 5) op = OP_IDLE;
         else if (r < 13) op = OP_HOLD;
         else if (r < 58) op = OP_EVAL;
         else op = OP_JOINT;
         for (int i = 0; i < 3; i++) begin
            if (op == OP_HOLD) p[32*i +: 32] = rnd_word(30, 1 << 20);
            else p[32*i +: 32] = hold_pos[32*i +: 32] + rnd_word(15, 4096);
            v[32*i +: 32] = rnd_word(25, 1 << 16);
         end
         if (op == OP_HOLD) hold_pos = p;
         j = 48'({$urandom(), $urandom()});
         tin = rnd_word(30, 1 << 20);
         tk = $urandom();
         if (op == OP_EVAL) begin
            r = $urandom_range(99);
            if (r < 2) tick_now = $urandom();
            else if (r < 10) tick_now += $urandom_range(65535);
            else tick_now += $urandom_range(200);
            tk = tick_now;
         end
         send_req(op, pack_req(p, v, tk, j, tin));
      end
   endtask

   initial begin
      #10_000_000;
      $display("tb NOT OK");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      stall_pct = 28;
      write_gains(G_ONES, G_ONES, G_ONES);

      // torque passthrough and ignored eval while not holding
      send_req(OP_JOINT, pack_req('0, '0, '0, 48'hFFFF_FFFF_FFFF, W_MAX));
      send_req(OP_JOINT, pack_req('0, '0, '0, 48'h8000_7FFF_8000, W_MIN));
      send_req(OP_EVAL, pack_req({W_MAX, W_MAX, W_MAX}, {W_MIN, W_MAX, W_MIN},
                                 32'hFFFF_FFFF, '0, W_MAX));
      send_req(OP_IDLE, pack_req({3{32'hFFFF_FFFF}}, {3{32'hFFFF_FFFF}},
                                 32'hFFFF_FFFF, G_ONES, 32'hFFFF_FFFF));
      // hold at extremes, then errors of largest magnitude
      send_req(OP_HOLD, pack_req({W_MAX, W_MIN, W_MIN}, '0, '0, '0, '0));
      send_req(OP_EVAL, pack_req({W_MIN, W_MAX, W_MAX}, {32'd0, W_MIN, W_MAX},
                                 32'hFFFF_FFF0, '0, '0));
      send_req(OP_EVAL, pack_req({W_MIN, W_MAX, W_MAX}, {W_MAX, 32'd0, W_MIN},
                                 32'h0000_0010, '0, '0));
      send_req(OP_EVAL, pack_req({W_MIN, W_MAX, W_MAX}, '0, 32'h8000_0010, '0, '0));
      send_req(OP_EVAL, pack_req({W_MIN, W_MAX, W_MAX}, '0, 32'h0000_0010, '0, '0));
      send_req(OP_JOINT, pack_req('0, '0, '0, 48'h7FFF_8000_7FFF, W_MAX));
      send_req(OP_JOINT, pack_req('0, '0, '0, 48'h8000_8000_8000, W_MIN));
      send_req(OP_JOINT, pack_req('0, '0, '0, '0, '0));
      // re-hold while holding, dt wrap to the top
      send_req(OP_HOLD, pack_req('0, '0, '0, '0, '0));
      send_req(OP_EVAL, pack_req({32'd3, -32'd7, 32'd100}, {32'd1, 32'd2, 32'd3},
                                 32'd5, '0, '0));
      send_req(OP_EVAL, pack_req({32'd3, -32'd7, 32'd100}, {32'd1, 32'd2, 32'd3},
                                 32'd4, '0, '0));
      send_req(OP_JOINT, pack_req('0, '0, '0, 48'h1234_C000_4000, 32'd77));
      // force kept over idle
      send_req(OP_IDLE, pack_req('0, '0, '0, '0, '0));
      send_req(OP_JOINT, pack_req('0, '0, '0, 48'h4000_4000_4000, -32'd5));
      send_req(OP_EVAL, pack_req({3{32'd9}}, '0, 32'd99, '0, '0));
      send_req(OP_HOLD, pack_req('0, '0, '0, '0, '0));
      send_req(OP_JOINT, pack_req('0, '0, '0, 48'h4000_4000_4000, '0));
      send_req(OP_EVAL, pack_req('0, {W_MAX, W_MIN, W_MAX}, 32'd200, '0, '0));
      send_req(OP_JOINT, pack_req('0, '0, '0, 48'h7FFF_7FFF_7FFF, '0));

      for (int ph = 0; ph < 4; ph++) begin
         wait_all_done();
         case (ph)
            0: begin
               send_pct = 0;
               stall_pct = 0;
               write_gains(48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}),
                           48'({$urandom(), $urandom()}));
            end
            1: begin
               send_pct = 45;
               stall_pct = 0;
               write_gains('0, '0, '0);
            end
            2: begin
               send_pct = 0;
               stall_pct = 45;
               write_gains({16'($urandom_range(255)), 16'($urandom_range(255)),
                            16'($urandom_range(255))},
                           {16'($urandom_range(15)), 16'($urandom_range(15)),
                            16'($urandom_range(15))},
                           {16'($urandom_range(255)), 16'($urandom_range(255)),
                            16'($urandom_range(255))});
            end
            default: begin
               send_pct = 28;
               stall_pct = 28;
               write_gains(48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}),
                           48'({$urandom(), $urandom()}));
            end
         endcase
         run_random(325);
      end

      wait_all_done();
      $display("covered %0d req beats (eval %0d, joint %0d, hold %0d, idle %0d), %0d rsp beats",
               sb.seen_op[OP_EVAL] + sb.seen_op[OP_JOINT] + sb.seen_op[OP_HOLD]
               + sb.seen_op[OP_IDLE], sb.seen_op[OP_EVAL], sb.seen_op[OP_JOINT],
               sb.seen_op[OP_HOLD], sb.seen_op[OP_IDLE], sb.checked);
      $display("gain sets all-ones, all-zero, small and random over four idle/stall mixes; %0d mismatches",
               sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
